>>> src/wpd_pkg.sv
// Shared types and constants for the worker pool dispatcher.
`default_nettype none
package wpd_pkg;

   localparam int NUM_WORKERS = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int CONN_WIDTH  = 16;
   localparam int CMD_DEPTH   = 2;

   localparam int WIDX_W  = 3;
   localparam int BUSY_W  = 4;
   localparam int FILL_W  = 5;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CPTR_W  = $clog2(CMD_DEPTH);
   localparam int CCNT_W  = $clog2(CMD_DEPTH + 1);

   typedef enum logic [0:0] {
      REQ_NEW    = 1'b0,
      REQ_FINISH = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_ASSIGNED    = 3'd0,
      ST_QUEUED      = 3'd1,
      ST_DROPPED     = 3'd2,
      ST_FREED       = 3'd3,
      ST_IDLE_FINISH = 3'd4
   } status_type;

   typedef struct packed {
      logic [0:0]  req_type;
      logic [15:0] conn_id;
      logic [2:0]  worker_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  assigned_worker;
      logic [15:0] assigned_conn;
      logic [3:0]  busy_workers;
      logic [4:0]  waiting_count;
   } rsp_type;

   typedef struct packed {
      logic                  is_finish;
      logic                  wid_ok;
      logic [WIDX_W-1:0]     widx;
      logic [CONN_WIDTH-1:0] conn;
   } cmd_type;

endpackage
`default_nettype wire

>>> src/wpd_front.sv
// Front end: accepts requests and classifies them into commands.
`default_nettype none
module wpd_front (
   input  wire logic             start,
   input  wire logic             queue_full,
   input  wire wpd_pkg::req_type req_item,
   output logic                  busy,
   output logic                  push,
   output wpd_pkg::cmd_type      push_cmd
);
   import wpd_pkg::*;

   always_comb begin
      busy               = queue_full;
      push               = start && !queue_full;
      push_cmd.is_finish = (req_kind_type'(req_item.req_type) == REQ_FINISH);
      push_cmd.wid_ok    = (32'(req_item.worker_id) < NUM_WORKERS);
      push_cmd.widx      = req_item.worker_id[WIDX_W-1:0];
      push_cmd.conn      = req_item.conn_id[CONN_WIDTH-1:0];
   end

endmodule
`default_nettype wire

>>> src/wpd_cmd_queue.sv
// Short command queue between the front end and the dispatch engine.
`default_nettype none
module wpd_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire wpd_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output wpd_pkg::cmd_type      pop_cmd
);
   import wpd_pkg::*;

   cmd_type           slot_ff [CMD_DEPTH];
   logic [CPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   always_comb begin
      full    = (32'(count_ff) == CMD_DEPTH);
      empty   = (count_ff == '0);
      pop_cmd = slot_ff[rd_ptr_ff];
      do_pop  = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == CMD_DEPTH - 1) ? '0 : wr_ptr_ff + CPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == CMD_DEPTH - 1) ? '0 : rd_ptr_ff + CPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CCNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> src/wpd_back.sv
// Dispatch engine: worker pool state, overflow FIFO and result register.
`default_nettype none
module wpd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire wpd_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   output logic                  rsp_strobe,
   output wpd_pkg::rsp_type      rsp_item
);
   import wpd_pkg::*;

   logic [NUM_WORKERS-1:0] busy_ff, busy_in;
   logic [BUSY_W-1:0]      busy_total_ff, busy_total_in;
   logic [QPTR_W-1:0]      head_ff, head_in;
   logic [QPTR_W-1:0]      tail_ff, tail_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [CONN_WIDTH-1:0]  wait_store [QUEUE_DEPTH];
   logic [CONN_WIDTH-1:0]  head_data_ff;
   logic                   wr_en;
   logic                   free_found;
   logic [WIDX_W-1:0]      free_idx;
   logic                   strobe_ff, strobe_in;
   rsp_type                rsp_ff, rsp_in;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = WIDX_W'(i);
         end
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      busy_total_in = busy_total_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      wr_en         = 1'b0;
      cmd_pop       = cmd_valid;
      strobe_in     = cmd_valid;
      rsp_in.status          = ST_IDLE_FINISH;
      rsp_in.assigned_worker = '0;
      rsp_in.assigned_conn   = '0;
      if (cmd_valid) begin
         if (!cmd.is_finish) begin
            if (free_found) begin
               busy_in[free_idx]      = 1'b1;
               busy_total_in          = busy_total_ff + BUSY_W'(1);
               rsp_in.status          = ST_ASSIGNED;
               rsp_in.assigned_worker = 3'(free_idx);
               rsp_in.assigned_conn   = 16'(cmd.conn);
            end else if (32'(fill_ff) < QUEUE_DEPTH) begin
               wr_en         = 1'b1;
               tail_in       = (32'(tail_ff) == QUEUE_DEPTH - 1) ? '0 : tail_ff + QPTR_W'(1);
               fill_in       = fill_ff + FILL_W'(1);
               rsp_in.status = ST_QUEUED;
            end else begin
               rsp_in.status = ST_DROPPED;
            end
         end else if (!cmd.wid_ok || !busy_ff[cmd.widx]) begin
            rsp_in.status = ST_IDLE_FINISH;
         end else if (fill_ff != '0) begin
            head_in                = (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + QPTR_W'(1);
            fill_in                = fill_ff - FILL_W'(1);
            rsp_in.status          = ST_ASSIGNED;
            rsp_in.assigned_worker = 3'(cmd.widx);
            rsp_in.assigned_conn   = 16'(head_data_ff);
         end else begin
            busy_in[cmd.widx] = 1'b0;
            if (busy_total_ff != '0) begin
               busy_total_in = busy_total_ff - BUSY_W'(1);
            end
            rsp_in.status = ST_FREED;
         end
      end
      rsp_in.busy_workers  = 4'(busy_total_in);
      rsp_in.waiting_count = 5'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wait_store[tail_ff] <= cmd.conn;
      end
      if (wr_en && tail_ff == head_in) begin
         head_data_ff <= cmd.conn;
      end else begin
         head_data_ff <= wait_store[head_in];
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         busy_total_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         busy_total_ff <= busy_total_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         strobe_ff     <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

>>> src/worker_pool_dispatcher_unit.sv
// Top level of the worker pool dispatcher.
// Result path: a transfer accepted into the command queue is registered there, then
// dispatched and registered in the result register, which shows it for one cycle.
// Throughput: one transfer per cycle; the dispatch engine drains one command per cycle
// from the two-entry command queue, so busy rises only if that queue fills.
// Reset clears the pool, the overflow FIFO pointers and the command queue.
`default_nettype none
module worker_pool_dispatcher_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wpd_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output wpd_pkg::rsp_type      rsp_item
);
   import wpd_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    cmd_pop;
   cmd_type pop_cmd;

   wpd_front u_front (
      .start      (start),
      .queue_full (queue_full),
      .req_item   (req_item),
      .busy       (busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   wpd_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .pop_cmd  (pop_cmd)
   );

   wpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!queue_empty),
      .cmd        (pop_cmd),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire

>>> src/wpd_checker.sv
// Port-level checks for the worker pool dispatcher, bound to the top level.
`default_nettype none
module wpd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_strobe,
   input wire wpd_pkg::rsp_type rsp_item
);
   import wpd_pkg::*;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("transfer accepted without a result two edges later");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_item.busy_workers) <= NUM_WORKERS &&
                      32'(rsp_item.waiting_count) <= QUEUE_DEPTH))
      else $error("busy or waiting count out of range");

   a_assign_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_ASSIGNED) |-> rsp_item.busy_workers != '0)
      else $error("assignment reported with no busy worker");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_DROPPED) |->
         (32'(rsp_item.waiting_count) == QUEUE_DEPTH &&
          32'(rsp_item.busy_workers) == NUM_WORKERS))
      else $error("drop reported while FIFO or pool had room");

endmodule

bind worker_pool_dispatcher_unit wpd_checker u_checker (.*);
`default_nettype wire
